// File: hdl/sfrd_pkg.sv
// Shared types, register indexes and helpers for the sprite frame run decoder.
package sfrd_pkg;

  // Widths of the fixed fields.
  localparam int BYTE_W  = 8;
  localparam int COORD_W = 11;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 11;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_COMPRESSED_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LEFT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TOP       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS      = 3'd4;

  // Row header size in bytes and the transparent palette index.
  localparam logic [15:0]       HDR_BYTES   = 16'd2;
  localparam logic [BYTE_W-1:0] TRANSPARENT = 8'd0;
  localparam logic [COORD_W-1:0] COORD_MAX  = 11'd2047;

  // One decoded run; pixel_index sits in the lowest bits.
  typedef struct packed {
    logic               frame_last;
    logic               row_last;
    logic [COORD_W-1:0] y_pos;
    logic [COORD_W-1:0] x_start;
    logic [BYTE_W-1:0]  run_length;
    logic [BYTE_W-1:0]  pixel_index;
  } sfrd_res_t;

  // Clamp a 12-bit coordinate sum to the 11-bit image range.
  function automatic logic [COORD_W-1:0] sat_coord(input logic [COORD_W:0] v);
    sat_coord = v[COORD_W] ? COORD_MAX : v[COORD_W-1:0];
  endfunction

endpackage

// File: hdl/sfrd_out_skid.sv
// Output register with a skid entry for decoded runs.
module sfrd_out_skid (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  sfrd_pkg::sfrd_res_t   push_res,
  output logic                  full,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output sfrd_pkg::sfrd_res_t   out_res
);
  import sfrd_pkg::*;

  logic      main_vld_r, main_vld_nxt;
  logic      skid_vld_r, skid_vld_nxt;
  sfrd_res_t main_res_r, main_res_nxt;
  sfrd_res_t skid_res_r, skid_res_nxt;
  logic      main_free;

  // The main register can take a new run when empty or being drained.
  assign main_free = !main_vld_r || out_tready;

  // Skid data comes first; the pusher must push only while the skid is empty; this block does not enforce it.
  always_comb begin
    main_vld_nxt = main_vld_r;
    main_res_nxt = main_res_r;
    skid_vld_nxt = skid_vld_r;
    skid_res_nxt = skid_res_r;
    if (main_free) begin
      if (skid_vld_r) begin
        main_vld_nxt = 1'b1;
        main_res_nxt = skid_res_r;
        skid_vld_nxt = 1'b0;
      end else begin
        main_vld_nxt = push;
        main_res_nxt = push_res;
      end
    end else if (push) begin
      skid_vld_nxt = 1'b1;
      skid_res_nxt = push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
    main_res_r <= main_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign full       = skid_vld_r;
  assign out_tvalid = main_vld_r;
  assign out_res    = main_res_r;

endmodule

// File: hdl/shape_frame_rle_decoder_core.sv
// Top level of the sprite frame zero-run / raw pixel decoder.
//
//   Channel   Direction  Payload
//   in_*      slave      tdata: data_byte[7:0]
//   out_*     master     tdata: pixel_index, run_length, x_start, y_pos; tlast: row_last;
//                        tuser: frame_last
//   cfg_*     write only index 0..4: mode, left, top, cols, rows
//
// One byte is taken every cycle while the skid entry is free. A byte is
// registered at the input, decoded against the phase and counter registers,
// and its run (if any) lands in the output register. A skid entry behind
// the output register absorbs one run while the result side stalls; the input
// side stops only when that entry is full.
// Reset is synchronous and active low; it returns to the row header phase.
module shape_frame_rle_decoder_core #(
  parameter int MAX_DIM = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [7:0] data_byte
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [7:0] pixel_index, [15:8] run_length, [26:16] x_start, [37:27] y_pos
  output logic [39:0]                         out_tdata,
  output logic                                out_tlast,  // row_last
  output logic                                out_tuser,  // [0] frame_last
  input  logic                                cfg_we,
  input  logic [sfrd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sfrd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import sfrd_pkg::*;

  // Largest usable frame dimension and the row counter width it needs.
  localparam int DIM_CAP = (MAX_DIM > 2047) ? 2047 : MAX_DIM;
  localparam int ROW_W   = $clog2(DIM_CAP);
  localparam logic [COORD_W-1:0] DIM_CAP_W = COORD_W'(DIM_CAP);

  typedef enum logic [1:0] {
    PH_LEN_LO,
    PH_LEN_HI,
    PH_BODY,
    PH_COUNT
  } phase_t;

  // Configuration registers.
  logic               mode_r;
  logic [9:0]         left_r;
  logic [9:0]         top_r;
  logic [COORD_W-1:0] cols_r;
  logic [COORD_W-1:0] rows_r;

  // Input register.
  logic              byte_vld_r;
  logic [BYTE_W-1:0] byte_r;

  // Decoder state.
  phase_t             phase_r, phase_nxt;
  logic [BYTE_W-1:0]  len_lo_r, len_lo_nxt;
  logic [15:0]        tot_r, tot_nxt;
  logic [15:0]        pos_r, pos_nxt;
  logic [COORD_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;

  logic               skid_full;
  logic               proc;
  logic               emit;
  logic [BYTE_W-1:0]  em_idx;
  logic [BYTE_W-1:0]  em_run;
  logic               em_row_end;
  logic               frame_end;
  logic               at_end;
  logic [15:0]        pos_inc;
  logic [15:0]        hdr_len;
  logic [COORD_W-1:0] eff_cols;
  logic [COORD_W-1:0] eff_rows;
  sfrd_res_t          res;
  sfrd_res_t          out_res;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1;
      left_r <= '0;
      top_r  <= '0;
      cols_r <= COORD_W'(1);
      rows_r <= COORD_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COMPRESSED_MODE: mode_r <= cfg_wdata[0];
        CFG_FRAME_LEFT:      left_r <= cfg_wdata[9:0];
        CFG_FRAME_TOP:       top_r  <= cfg_wdata[9:0];
        CFG_FRAME_COLS:      cols_r <= cfg_wdata;
        CFG_FRAME_ROWS:      rows_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Zero dimensions count as one, large ones are capped.
  assign eff_cols = (cols_r == '0) ? COORD_W'(1) : ((cols_r > DIM_CAP_W) ? DIM_CAP_W : cols_r);
  assign eff_rows = (rows_r == '0) ? COORD_W'(1) : ((rows_r > DIM_CAP_W) ? DIM_CAP_W : rows_r);

  // A byte is decoded whenever one is held and the skid entry is free.
  assign proc      = byte_vld_r && !skid_full;
  assign in_tready = !(byte_vld_r && skid_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
    end else if (in_tready) begin
      byte_vld_r <= in_tvalid;
    end
    if (in_tready) begin
      byte_r <= in_tdata;
    end
  end

  assign pos_inc = pos_r + 16'd1;
  assign at_end  = pos_inc >= tot_r;
  assign hdr_len = {byte_r, len_lo_r};

  // Phase machine for one byte, then the common run bookkeeping.
  always_comb begin
    phase_nxt  = phase_r;
    len_lo_nxt = len_lo_r;
    tot_nxt    = tot_r;
    pos_nxt    = pos_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    emit       = 1'b0;
    em_idx     = TRANSPARENT;
    em_run     = '0;
    em_row_end = 1'b0;

    if (!mode_r) begin
      // Raw bytes: one pixel each, row ends by column count.
      emit       = 1'b1;
      em_idx     = byte_r;
      em_run     = 8'd1;
      em_row_end = ({1'b0, col_r} + 12'd1) >= {1'b0, eff_cols};
    end else begin
      case (phase_r)
        PH_LEN_LO: begin
          len_lo_nxt = byte_r;
          phase_nxt  = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          tot_nxt = (hdr_len < HDR_BYTES) ? HDR_BYTES : hdr_len;
          pos_nxt = HDR_BYTES;
          if (hdr_len <= HDR_BYTES) begin
            // Row with no body bytes.
            emit       = 1'b1;
            em_row_end = 1'b1;
          end else begin
            phase_nxt = PH_BODY;
          end
        end
        PH_BODY: begin
          pos_nxt = pos_inc;
          if (byte_r != TRANSPARENT) begin
            emit       = 1'b1;
            em_idx     = byte_r;
            em_run     = 8'd1;
            em_row_end = at_end;
          end else if (at_end) begin
            // Zero code as the row's last byte closes the row.
            emit       = 1'b1;
            em_row_end = 1'b1;
          end else begin
            phase_nxt = PH_COUNT;
          end
        end
        PH_COUNT: begin
          pos_nxt   = pos_inc;
          phase_nxt = PH_BODY;
          if (byte_r != 8'd0 || at_end) begin
            emit       = 1'b1;
            em_run     = byte_r;
            em_row_end = at_end;
          end
        end
        default: begin
          phase_nxt = PH_LEN_LO;
        end
      endcase
    end

    frame_end = em_row_end && (({1'b0, COORD_W'(row_r)} + 12'd1) >= {1'b0, eff_rows});

    if (emit) begin
      col_nxt = sat_coord({1'b0, col_r} + {4'd0, em_run});
      if (em_row_end) begin
        col_nxt   = '0;
        row_nxt   = frame_end ? '0 : row_r + ROW_W'(1);
        phase_nxt = PH_LEN_LO;
      end
    end
  end

  // Run fields use the position before this byte's update.
  always_comb begin
    res.pixel_index = em_idx;
    res.run_length  = em_run;
    res.x_start     = sat_coord({2'b00, left_r} + {1'b0, col_r});
    res.y_pos       = sat_coord({2'b00, top_r} + {1'b0, COORD_W'(row_r)});
    res.row_last    = em_row_end;
    res.frame_last  = frame_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_LEN_LO;
      len_lo_r <= '0;
      tot_r    <= '0;
      pos_r    <= '0;
      col_r    <= '0;
      row_r    <= '0;
    end else if (proc) begin
      phase_r  <= phase_nxt;
      len_lo_r <= len_lo_nxt;
      tot_r    <= tot_nxt;
      pos_r    <= pos_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

  // Result register with skid entry.
  sfrd_out_skid u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (proc && emit),
    .push_res   (res),
    .full       (skid_full),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {2'b00, out_res.y_pos, out_res.x_start, out_res.run_length,
                      out_res.pixel_index};
  assign out_tlast = out_res.row_last;
  assign out_tuser = out_res.frame_last;

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the sprite frame zero-run / raw pixel decoder.
`timescale 1ns / 1ps

module tb_top;
  import sfrd_pkg::*;

  localparam int MAX_DIM      = 1024;
  localparam int DRAIN_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RAND_ITEMS   = 330;

  // Decoder phases within a compressed row.
  typedef enum logic [1:0] {PH_HDR_LO, PH_HDR_HI, PH_BODY, PH_COUNT} row_phase_t;

  // One byte waiting to be sent; hold_for_drain pauses the sender until
  // every expected run has arrived.
  typedef struct packed {
    logic [7:0] data;
    logic       hold_for_drain;
  } pending_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;          // [7:0] data_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;                 // [7:0] pixel_index, [15:8] run_length,
                                          // [26:16] x_start, [37:27] y_pos
  logic        out_tlast;                 // row_last
  logic        out_tuser;                 // [0] frame_last
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  pending_byte_t stored_bytes[$];
  sfrd_res_t     expected_runs[$];
  logic          in_fired = 1'b0;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_idle_pct = 0;
  int unsigned   mismatches = 0;
  int unsigned   cycle_count = 0;
  int unsigned   pushed_items = 0;

  // Predictor copy of the configuration registers.
  logic        mode_compressed = 1'b1;
  logic [9:0]  left_cfg = '0;
  logic [9:0]  top_cfg = '0;
  logic [10:0] cols_cfg = 11'd1;
  logic [10:0] rows_cfg = 11'd1;

  // Predictor copy of the decoder state.
  row_phase_t  row_phase = PH_HDR_LO;
  logic [7:0]  len_lo = '0;
  logic [15:0] row_total = '0;
  logic [15:0] row_bpos = '0;
  int unsigned col_cnt = 0;
  int unsigned row_cnt = 0;

  shape_frame_rle_decoder_core #(.MAX_DIM(MAX_DIM)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Frame dimensions: zero counts as one, oversized values clip to the maximum.
  function automatic int unsigned eff_dim(input logic [10:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic logic [COORD_W-1:0] clip_coord(input int unsigned v);
    return (v > COORD_MAX) ? COORD_MAX : v[COORD_W-1:0];
  endfunction

  // Build one run at the current position and advance the column and row.
  function automatic sfrd_res_t make_run(input logic [7:0] idx, input logic [7:0] len,
                                         input bit row_end);
    sfrd_res_t r;
    bit        frame_end;
    frame_end     = row_end && (row_cnt + 1 >= eff_dim(rows_cfg));
    r.pixel_index = idx;
    r.run_length  = len;
    r.x_start     = clip_coord(left_cfg + col_cnt);
    r.y_pos       = clip_coord(top_cfg + row_cnt);
    r.row_last    = row_end;
    r.frame_last  = frame_end;
    col_cnt = clip_coord(col_cnt + len);
    if (row_end) begin
      col_cnt   = 0;
      row_cnt   = frame_end ? 0 : row_cnt + 1;
      row_phase = PH_HDR_LO;
    end
    return r;
  endfunction

  // Decode one stored byte; returns 1 when the byte completes a run.
  function automatic bit decode_byte(input logic [7:0] b, output sfrd_res_t run);
    bit at_end;
    run = '0;
    if (!mode_compressed) begin
      run = make_run(b, 8'd1, col_cnt + 1 >= eff_dim(cols_cfg));
      return 1'b1;
    end
    case (row_phase)
      PH_HDR_LO: begin
        len_lo    = b;
        row_phase = PH_HDR_HI;
        return 1'b0;
      end
      PH_HDR_HI: begin
        row_total = {b, len_lo};
        if (row_total < HDR_BYTES) row_total = HDR_BYTES;
        row_bpos = HDR_BYTES;
        if (row_total == HDR_BYTES) begin
          run = make_run(TRANSPARENT, 8'd0, 1'b1);
          return 1'b1;
        end
        row_phase = PH_BODY;
        return 1'b0;
      end
      PH_BODY: begin
        row_bpos = row_bpos + 16'd1;
        at_end   = row_bpos >= row_total;
        if (b != 8'd0) begin
          run = make_run(b, 8'd1, at_end);
          return 1'b1;
        end
        if (at_end) begin
          run = make_run(TRANSPARENT, 8'd0, 1'b1);
          return 1'b1;
        end
        row_phase = PH_COUNT;
        return 1'b0;
      end
      default: begin
        row_bpos  = row_bpos + 16'd1;
        at_end    = row_bpos >= row_total;
        row_phase = PH_BODY;
        if (b == 8'd0 && !at_end) return 1'b0;
        run = make_run(TRANSPARENT, b, at_end);
        return 1'b1;
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // Sender: one byte per transfer, random gaps, optional drain pause.
  always @(negedge clk) begin
    pending_byte_t nxt;
    logic          next_valid;
    logic [7:0]    next_data;
    next_valid = in_tvalid;
    next_data  = in_tdata;
    if (rst_n && (!in_tvalid || in_fired)) begin
      next_valid = 1'b0;
      if (stored_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct &&
          !(stored_bytes[0].hold_for_drain && expected_runs.size() != 0)) begin
        nxt        = stored_bytes.pop_front();
        next_valid = 1'b1;
        next_data  = nxt.data;
      end
    end
    in_tvalid <= next_valid;
    in_tdata  <= next_data;
  end

  // Receiver backpressure.
  always @(negedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: check each result transfer, then predict from each input transfer.
  always @(posedge clk) begin
    sfrd_res_t exp_run;
    sfrd_res_t got_run;
    sfrd_res_t new_run;
    if (!rst_n) begin
      in_fired <= 1'b0;
    end else begin
      in_fired <= in_tvalid && in_tready;
      if (out_tvalid && out_tready) begin
        if (expected_runs.size() == 0) begin
          $error("run transfer with nothing expected: tdata %h", out_tdata);
          mismatches++;
        end else begin
          exp_run = expected_runs.pop_front();
          got_run = {out_tuser, out_tlast, out_tdata[37:0]};
          check_field("pixel_index", exp_run.pixel_index, got_run.pixel_index);
          check_field("run_length", exp_run.run_length, got_run.run_length);
          check_field("x_start", exp_run.x_start, got_run.x_start);
          check_field("y_pos", exp_run.y_pos, got_run.y_pos);
          check_field("row_last", exp_run.row_last, got_run.row_last);
          check_field("frame_last", exp_run.frame_last, got_run.frame_last);
          check_field("tdata_pad", 0, out_tdata[39:38]);
        end
      end
      if (in_tvalid && in_tready) begin
        if (decode_byte(in_tdata, new_run)) expected_runs.push_back(new_run);
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic hold = 1'b0);
    pending_byte_t p;
    p.data           = b;
    p.hold_for_drain = hold;
    stored_bytes.push_back(p);
    pushed_items++;
  endtask

  // Row body content, biased toward zero codes and zero counts.
  function automatic logic [7:0] body_byte();
    return ($urandom_range(99) < 30) ? 8'd0 : 8'($urandom_range(255));
  endfunction

  // Register write; the predictor takes the same value at once since the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_COMPRESSED_MODE: mode_compressed = val[0];
      CFG_FRAME_LEFT:      left_cfg = val[9:0];
      CFG_FRAME_TOP:       top_cfg = val[9:0];
      CFG_FRAME_COLS:      cols_cfg = val;
      CFG_FRAME_ROWS:      rows_cfg = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until all bytes are sent and all runs seen, then let the pipe empty.
  task automatic settle();
    do begin
      @(posedge clk);
      #1;
    end while (stored_bytes.size() != 0 || in_tvalid || expected_runs.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_offset();
    case ($urandom_range(3))
      0: return '0;
      1: return 11'd1023;
      2: return 11'($urandom_range(2047));
      default: return 11'($urandom_range(40));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    case ($urandom_range(7))
      0: return '0;
      1: return 11'd1;
      2: return 11'd1024;
      3: return 11'($urandom_range(1025, 2047));
      default: return 11'($urandom_range(2, 12));
    endcase
  endfunction

  // Declared row length: mostly short rows, some empty or undersized, rarely long.
  function automatic int unsigned pick_row_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 6) return $urandom_range(1);
    if (r < 14) return 2;
    if (r < 16) return $urandom_range(256, 300);
    return $urandom_range(3, 30);
  endfunction

  // Finish whatever compressed row the decoder is in so new rows line up.
  task automatic finish_open_row();
    int unsigned remaining;
    remaining = 0;
    case (row_phase)
      PH_HDR_LO: remaining = 0;
      PH_HDR_HI: begin
        push_byte(8'h00);
        remaining = (len_lo < HDR_BYTES) ? 0 : len_lo - HDR_BYTES;
      end
      default: remaining = (row_total > row_bpos) ? row_total - row_bpos : 0;
    endcase
    repeat (remaining) push_byte(body_byte());
  endtask

  // One random phase: new settings, then a burst of rows or raw pixels.
  task automatic run_random_phase();
    int unsigned target;
    int unsigned sent;
    int unsigned row_len;
    int unsigned body_len;
    write_reg(CFG_COMPRESSED_MODE, 11'($urandom_range(3) != 0));
    write_reg(CFG_FRAME_LEFT, pick_offset());
    write_reg(CFG_FRAME_TOP, pick_offset());
    write_reg(CFG_FRAME_COLS, pick_dim());
    write_reg(CFG_FRAME_ROWS, pick_dim());
    if ($urandom_range(3) == 0)
      write_reg(CFG_IDX_W'(CFG_FRAME_ROWS + $urandom_range(1, 3)), 11'($urandom_range(2047)));
    target = $urandom_range(15, 45);
    if (!mode_compressed) begin
      repeat (target) push_byte(8'($urandom_range(255)), $urandom_range(39) == 0);
    end else begin
      finish_open_row();
      sent = 0;
      while (sent < target) begin
        row_len  = pick_row_len();
        body_len = (row_len < HDR_BYTES) ? 0 : row_len - HDR_BYTES;
        // The last row of a phase is sometimes cut short.
        if (sent + body_len + 2 >= target && $urandom_range(1) == 0)
          body_len = $urandom_range(body_len);
        push_byte(row_len[7:0], $urandom_range(19) == 0);
        push_byte(row_len[15:8]);
        repeat (body_len) push_byte(body_byte());
        sent += body_len + 2;
      end
    end
    settle();
  endtask

  // Main sequence.
  initial begin
    int unsigned seg;
    int unsigned seg_end;
    send_idle_pct = 33;
    recv_idle_pct = 62;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: spare indexes, saturated offsets, empty rows, zero runs.
    write_reg(CFG_IDX_W'(CFG_FRAME_ROWS + 1), '1);
    write_reg(CFG_IDX_W'(CFG_FRAME_ROWS + 3), '0);
    write_reg(CFG_FRAME_LEFT, 11'd1023);
    write_reg(CFG_FRAME_TOP, 11'd1023);
    write_reg(CFG_FRAME_ROWS, 11'd3);
    write_reg(CFG_FRAME_COLS, 11'd2047);
    // Undersized length: empty row.
    push_byte(8'h00); push_byte(8'h00);
    // Five full zero runs push x past the image edge, then a literal ends the row.
    push_byte(8'h0D); push_byte(8'h00);
    repeat (5) begin
      push_byte(8'h00); push_byte(8'hFF);
    end
    push_byte(8'h42);
    // Literal, zero count inside the row, zero code as the last byte; ends the frame.
    push_byte(8'h06, 1'b1); push_byte(8'h00);
    push_byte(8'hFF); push_byte(8'h00); push_byte(8'h00); push_byte(8'h00);
    // Zero count at the row end.
    push_byte(8'h04); push_byte(8'h00); push_byte(8'h00); push_byte(8'h00);
    settle();
    // Raw pixels across a short row.
    write_reg(CFG_COMPRESSED_MODE, 11'd0);
    write_reg(CFG_FRAME_LEFT, 11'd0);
    write_reg(CFG_FRAME_TOP, 11'd0);
    write_reg(CFG_FRAME_COLS, 11'd3);
    write_reg(CFG_FRAME_ROWS, 11'd2);
    push_byte(8'h00); push_byte(8'hFF); push_byte(8'h01);
    settle();

    // Random phases under three idle patterns.
    for (seg = 0; seg < 3; seg++) begin
      case (seg)
        0: begin send_idle_pct = 33; recv_idle_pct = 62; end
        1: begin send_idle_pct = 62; recv_idle_pct = 33; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      seg_end = pushed_items + RAND_ITEMS / 3;
      while (pushed_items < seg_end) run_random_phase();
    end

    settle();
    if (mismatches == 0 && expected_runs.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
